@@ sv/elp_pkg.sv @@
// package: shared constants and types for the event latency profiler
`timescale 1ns / 1ps
package elp_pkg;
  localparam int NUM_IDS_DEF = 512;
  localparam int MAX_REPORT_ROWS_DEF = 24;
  localparam logic [4:0] DEPTH_RST = 5'd24;
  localparam logic [11:0] EXIT_A_RST = 12'd60;
  localparam logic [11:0] EXIT_B_RST = 12'd231;

  localparam logic [1:0] MODE_ENTER = 2'd0;
  localparam logic [1:0] MODE_EXIT = 2'd1;
  localparam logic [1:0] MODE_REPORT = 2'd2;
  localparam logic [1:0] MODE_CLEAR = 2'd3;

  localparam logic [1:0] REG_DEPTH = 2'd0;
  localparam logic [1:0] REG_EXIT_A = 2'd1;
  localparam logic [1:0] REG_EXIT_B = 2'd2;

  typedef struct packed {
    logic start;
    logic [63:0] num;
    logic [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [63:0] quo;
  } div_rsp_t;
endpackage

@@ sv/elp_div.sv @@
// radix-2 restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module elp_div (
  input  logic clk,
  input  logic rst,
  input  elp_pkg::div_req_t req,
  output elp_pkg::div_rsp_t rsp
);
  import elp_pkg::*;
  logic [63:0] quo;
  logic [64:0] rem;
  logic [63:0] den;
  logic [6:0] cnt;
  logic run;
  logic done;
  logic [64:0] trial;

  always_comb begin
    trial = {rem[63:0], quo[63]} - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run <= 1'b1;
        cnt <= 7'd64;
        quo <= req.num;
        den <= req.den;
        rem <= '0;
      end else if (run) begin
        if (!trial[64]) begin
          rem <= trial;
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= {rem[63:0], quo[63]};
          quo <= {quo[62:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp = {done, quo};
endmodule

@@ sv/event_latency_profiler_top_n.sv @@
// top level: per-id latency profiler with ranked report
// enter: latches the timestamp; for an exit id it runs a report first and latches it after
// exit: accept, read, then add and write back
// report: a ranking scan over all ids, the average divider for each row, then the totals row;
//   rows are one-cycle strobes; clear: one entry a cycle; after reset a clearing pass runs
//   with busy high; configuration writes are taken at any time
`timescale 1ns / 1ps
module event_latency_profiler_top_n #(
  parameter int NUM_IDS = elp_pkg::NUM_IDS_DEF,
  parameter int MAX_REPORT_ROWS = elp_pkg::MAX_REPORT_ROWS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic [1:0] mode,
  input  logic [11:0] event_id,
  input  logic counted,
  input  logic [63:0] timestamp,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [11:0] cfg_data,
  output logic valid,
  output logic row_kind,
  output logic [8:0] row_id,
  output logic [63:0] row_count,
  output logic [63:0] row_total,
  output logic [63:0] row_average,
  output logic last
);
  import elp_pkg::*;
  localparam int IW = $clog2(NUM_IDS);
  localparam int RW = $clog2(MAX_REPORT_ROWS + 1);
  localparam int LW = (MAX_REPORT_ROWS > 1) ? $clog2(MAX_REPORT_ROWS) : 1;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_CLR   = 12'b000000000010,
    S_XRD   = 12'b000000000100,
    S_XWR   = 12'b000000001000,
    S_SRD   = 12'b000000010000,
    S_SCAN  = 12'b000000100000,
    S_CMP   = 12'b000001000000,
    S_ORD   = 12'b000010000000,
    S_ORDW  = 12'b000100000000,
    S_ODIV  = 12'b001000000000,
    S_OWAIT = 12'b010000000000,
    S_TOT   = 12'b100000000000
  } state_t;

  state_t state;
  logic [4:0] report_depth;
  logic [11:0] exit_id_a, exit_id_b;
  logic [63:0] enter_time;
  logic [63:0] cnt_mem [NUM_IDS];
  logic [63:0] tot_mem [NUM_IDS];
  logic [63:0] rd_cnt, rd_tot;
  logic [IW-1:0] addr;
  logic [IW:0] idx;
  logic [IW-1:0] cur_id;
  logic [63:0] sum_c, sum_t;
  logic [IW-1:0] rank [MAX_REPORT_ROWS];
  logic [63:0] rank_tot [MAX_REPORT_ROWS];
  logic [RW-1:0] filled, depth, pos, k;
  logic [63:0] ts_l;
  logic post_enter;
  logic [63:0] dt;
  div_req_t dreq;
  div_rsp_t drsp;

  elp_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign busy = (state != S_IDLE);
  assign dt = (ts_l > enter_time) ? ts_l - enter_time : 64'd0;

  always_ff @(posedge clk) begin
    rd_cnt <= cnt_mem[addr];
    rd_tot <= tot_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (state == S_CLR) begin
      cnt_mem[idx[IW-1:0]] <= '0;
      tot_mem[idx[IW-1:0]] <= '0;
    end else if (state == S_XWR) begin
      cnt_mem[addr] <= rd_cnt + 64'd1;
      tot_mem[addr] <= rd_tot + dt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      report_depth <= DEPTH_RST;
      exit_id_a <= EXIT_A_RST;
      exit_id_b <= EXIT_B_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEPTH: report_depth <= cfg_data[4:0];
        REG_EXIT_A: exit_id_a <= cfg_data;
        REG_EXIT_B: exit_id_b <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      idx <= '0;
      enter_time <= '0;
      valid <= 1'b0;
      dreq.start <= 1'b0;
      post_enter <= 1'b0;
    end else begin
      valid <= 1'b0;
      dreq.start <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            ts_l <= timestamp;
            addr <= event_id[IW-1:0];
            idx <= '0;
            case (mode)
              MODE_ENTER: begin
                if (counted) begin
                  if (event_id == exit_id_a || event_id == exit_id_b) begin
                    post_enter <= 1'b1;
                    state <= S_SRD;
                  end else enter_time <= timestamp;
                end
              end
              MODE_EXIT: begin
                if (counted && {20'd0, event_id} < NUM_IDS) state <= S_XRD;
              end
              MODE_REPORT: begin
                post_enter <= 1'b0;
                state <= S_SRD;
              end
              default: state <= S_CLR;
            endcase
            filled <= '0;
            sum_c <= '0;
            sum_t <= '0;
            depth <= ({27'd0, report_depth} > MAX_REPORT_ROWS) ?
                     RW'(MAX_REPORT_ROWS) : RW'(report_depth);
          end
        end
        S_CLR: begin
          idx <= idx + 1'b1;
          if (idx == (IW+1)'(NUM_IDS - 1)) state <= S_IDLE;
        end
        S_XRD: state <= S_XWR;
        S_XWR: state <= S_IDLE;
        S_SRD: begin
          if (idx == (IW+1)'(NUM_IDS)) begin
            k <= '0;
            state <= S_ORD;
          end else begin
            addr <= idx[IW-1:0];
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          // memory data lands in the cycle after the address
          cur_id <= addr;
          state <= S_CMP;
          pos <= filled;
        end
        S_CMP: begin
          if (rd_cnt == 64'd0) begin
            idx <= idx + 1'b1;
            state <= S_SRD;
          end else if (pos != '0 && rank_tot[LW'(pos - 1'b1)] < rd_tot) begin
            pos <= pos - 1'b1;
          end else begin
            sum_c <= sum_c + rd_cnt;
            sum_t <= sum_t + rd_tot;
            if (pos < depth) begin
              for (int j = MAX_REPORT_ROWS - 1; j > 0; j--) begin
                if (RW'(j) > pos) begin
                  rank[j] <= rank[j-1];
                  rank_tot[j] <= rank_tot[j-1];
                end
              end
              rank[LW'(pos)] <= cur_id;
              rank_tot[LW'(pos)] <= rd_tot;
              if (filled < depth) filled <= filled + 1'b1;
            end
            idx <= idx + 1'b1;
            state <= S_SRD;
          end
        end
        S_ORD: begin
          if (k == filled) state <= S_TOT;
          else begin
            addr <= rank[LW'(k)];
            state <= S_ORDW;
          end
        end
        S_ORDW: state <= S_ODIV;
        S_ODIV: begin
          dreq.start <= 1'b1;
          dreq.num <= rd_tot;
          dreq.den <= rd_cnt;
          state <= S_OWAIT;
        end
        S_OWAIT: begin
          if (drsp.done) begin
            valid <= 1'b1;
            row_kind <= 1'b0;
            row_id <= 9'(addr);
            row_count <= dreq.den;
            row_total <= dreq.num;
            row_average <= drsp.quo;
            last <= 1'b0;
            k <= k + 1'b1;
            state <= S_ORD;
          end
        end
        S_TOT: begin
          valid <= 1'b1;
          row_kind <= 1'b1;
          row_id <= '0;
          row_count <= sum_c;
          row_total <= sum_t;
          row_average <= '0;
          last <= 1'b1;
          if (post_enter) enter_time <= ts_l;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ sv/elp_checker.sv @@
// port-level checker for the event latency profiler, bound to the top level
`timescale 1ns / 1ps
module elp_checker (
  input logic clk,
  input logic rst,
  input logic busy,
  input logic valid,
  input logic row_kind,
  input logic [8:0] row_id,
  input logic [63:0] row_average,
  input logic last
);
  a_last_totals: assert property (@(posedge clk) disable iff (rst)
    valid |-> (last == row_kind)) else $error("last differs from row kind");
  a_tot_zero: assert property (@(posedge clk) disable iff (rst)
    (valid && row_kind) |-> (row_id == 9'd0 && row_average == 64'd0))
    else $error("totals row carries id or average");
  a_busy_rows: assert property (@(posedge clk) disable iff (rst)
    valid |-> $past(busy)) else $error("row while idle");
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (valid && last) |=> !valid) else $error("row after last");
endmodule

bind event_latency_profiler_top_n elp_checker u_elp_checker (
  .clk(clk), .rst(rst), .busy(busy), .valid(valid),
  .row_kind(row_kind), .row_id(row_id), .row_average(row_average), .last(last)
);

@@ bench/testbench.sv @@
// testbench for the event latency profiler: directed and random words against a built-in predictor
`timescale 1ns / 1ps
module testbench;
  import elp_pkg::*;

  localparam int IDS = 512;
  localparam int ROWS_MAX = 24;

  typedef struct {
    logic        kind;
    logic [8:0]  id;
    logic [63:0] count;
    logic [63:0] total;
    logic [63:0] average;
    logic        last;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  mode = MODE_ENTER;
  logic [11:0] event_id = '0;
  logic        counted = 1'b0;
  logic [63:0] timestamp = '0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_DEPTH;
  logic [11:0] cfg_data = '0;
  logic        valid;
  logic        row_kind;
  logic [8:0]  row_id;
  logic [63:0] row_count;
  logic [63:0] row_total;
  logic [63:0] row_average;
  logic        last;

  event_latency_profiler_top_n u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .mode(mode), .event_id(event_id), .counted(counted), .timestamp(timestamp),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .valid(valid), .row_kind(row_kind), .row_id(row_id), .row_count(row_count),
    .row_total(row_total), .row_average(row_average), .last(last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [4:0]  depth_reg = DEPTH_RST;
  logic [11:0] exit_a_reg = EXIT_A_RST;
  logic [11:0] exit_b_reg = EXIT_B_RST;
  logic [63:0] latched_enter = '0;
  logic [63:0] id_counts [IDS];
  logic [63:0] id_totals [IDS];
  row_t        pending_rows [$];
  int          errors = 0;
  int          idle_pct = 0;
  logic [63:0] clock_ns = 64'd1000;

  initial begin
    for (int i = 0; i < IDS; i++) begin
      id_counts[i] = '0;
      id_totals[i] = '0;
    end
  end

  function automatic void predict_report();
    int   depth;
    int   best;
    bit   taken [IDS];
    logic [63:0] sum_c;
    logic [63:0] sum_t;
    row_t r;
    depth = (depth_reg > ROWS_MAX) ? ROWS_MAX : depth_reg;
    sum_c = '0;
    sum_t = '0;
    for (int i = 0; i < IDS; i++) begin
      taken[i] = 1'b0;
      if (id_counts[i] != 0) begin
        sum_c += id_counts[i];
        sum_t += id_totals[i];
      end
    end
    for (int k = 0; k < depth; k++) begin
      best = -1;
      for (int i = 0; i < IDS; i++)
        if (id_counts[i] != 0 && !taken[i] && (best < 0 || id_totals[i] > id_totals[best]))
          best = i;
      if (best < 0) break;
      taken[best] = 1'b1;
      r.kind = 1'b0;
      r.id = best[8:0];
      r.count = id_counts[best];
      r.total = id_totals[best];
      r.average = id_totals[best] / id_counts[best];
      r.last = 1'b0;
      pending_rows.push_back(r);
    end
    r.kind = 1'b1;
    r.id = '0;
    r.count = sum_c;
    r.total = sum_t;
    r.average = '0;
    r.last = 1'b1;
    pending_rows.push_back(r);
  endfunction

  function automatic void predict_word(logic [1:0] m, logic [11:0] id, logic c, logic [63:0] ts);
    case (m)
      MODE_ENTER: begin
        if (c) begin
          if (id == exit_a_reg || id == exit_b_reg) predict_report();
          latched_enter = ts;
        end
      end
      MODE_EXIT: begin
        if (c && id < IDS) begin
          id_counts[id] += 64'd1;
          id_totals[id] += (ts > latched_enter) ? ts - latched_enter : 64'd0;
        end
      end
      MODE_REPORT: predict_report();
      default: begin
        for (int i = 0; i < IDS; i++) begin
          id_counts[i] = '0;
          id_totals[i] = '0;
        end
      end
    endcase
  endfunction

  // row checker
  always @(posedge clk) begin
    row_t e;
    if (!rst && valid) begin
      if (pending_rows.size() == 0) begin
        $display("%0t: unexpected row kind=%0d id=%0d count=%0d total=%0d", $time,
                 row_kind, row_id, row_count, row_total);
        errors++;
      end else begin
        e = pending_rows.pop_front();
        if (row_kind !== e.kind) begin
          $display("%0t: row_kind expected %0d actual %0d", $time, e.kind, row_kind);
          errors++;
        end
        if (row_id !== e.id) begin
          $display("%0t: row_id expected %0d actual %0d", $time, e.id, row_id);
          errors++;
        end
        if (row_count !== e.count) begin
          $display("%0t: row_count expected %0d actual %0d", $time, e.count, row_count);
          errors++;
        end
        if (row_total !== e.total) begin
          $display("%0t: row_total expected %0d actual %0d", $time, e.total, row_total);
          errors++;
        end
        if (row_average !== e.average) begin
          $display("%0t: row_average expected %0d actual %0d", $time, e.average,
                   row_average);
          errors++;
        end
        if (last !== e.last) begin
          $display("%0t: last expected %0d actual %0d", $time, e.last, last);
          errors++;
        end
      end
    end
  end

  task automatic send_word(logic [1:0] m, logic [11:0] id, logic c, logic [63:0] ts);
    int gap;
    start <= 1'b1;
    mode <= m;
    event_id <= id;
    counted <= c;
    timestamp <= ts;
    do @(posedge clk); while (busy);
    predict_word(m, id, c, ts);
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [11:0] data);
    if (start) begin
      start <= 1'b0;
      @(posedge clk);
    end
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    while (busy) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_DEPTH: depth_reg = data[4:0];
      REG_EXIT_A: exit_a_reg = data;
      default: exit_b_reg = data;
    endcase
  endtask

  task automatic pair(logic [11:0] id, logic [63:0] dt);
    clock_ns += 64'd17;
    send_word(MODE_ENTER, id, 1'b1, clock_ns);
    send_word(MODE_EXIT, id, 1'b1, clock_ns + dt);
    clock_ns += dt;
  endtask

  task automatic test_directed();
    idle_pct = 0;
    send_word(MODE_REPORT, 12'd0, 1'b0, '0);
    send_word(MODE_ENTER, 12'd5, 1'b0, 64'd999);
    send_word(MODE_EXIT, 12'd5, 1'b0, 64'd5000);
    pair(12'd3, 64'd100);
    pair(12'd9, 64'd100);
    pair(12'd0, 64'd40);
    pair(12'd511, 64'd250);
    send_word(MODE_EXIT, 12'd4095, 1'b1, 64'd123456);
    send_word(MODE_EXIT, 12'd512, 1'b1, 64'd123456);
    send_word(MODE_ENTER, 12'd7, 1'b1, '1);
    send_word(MODE_EXIT, 12'd7, 1'b1, 64'd10);
    send_word(MODE_EXIT, 12'd7, 1'b1, '1);
    send_word(MODE_ENTER, 12'd8, 1'b1, '0);
    send_word(MODE_EXIT, 12'd8, 1'b1, '1);
    send_word(MODE_EXIT, 12'd8, 1'b1, '1);
    send_word(MODE_ENTER, 12'd60, 1'b1, 64'd50);
    send_word(MODE_ENTER, 12'd231, 1'b1, 64'd60);
    send_word(MODE_REPORT, 12'd0, 1'b1, '0);
    send_word(MODE_CLEAR, 12'd0, 1'b0, '0);
    send_word(MODE_REPORT, 12'd0, 1'b0, '0);
    clock_ns = 64'd1000;
  endtask

  task automatic test_registers();
    write_reg(REG_DEPTH, 12'd0);
    pair(12'd2, 64'd30);
    send_word(MODE_REPORT, 12'd0, 1'b0, '0);
    write_reg(REG_DEPTH, 12'd31);
    write_reg(REG_EXIT_A, 12'd4095);
    write_reg(REG_EXIT_B, 12'd0);
    pair(12'd4, 64'd77);
    send_word(MODE_ENTER, 12'd0, 1'b1, clock_ns);
    write_reg(REG_DEPTH, 12'd1);
    send_word(MODE_ENTER, 12'd4095, 1'b1, clock_ns);
  endtask

  task automatic run_random(int count, int pct);
    int r;
    logic [11:0] id;
    logic [63:0] dt;
    idle_pct = pct;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 78) begin
        id = ($urandom_range(3) == 0) ? 12'($urandom_range(511)) : 12'($urandom_range(31));
        if (id == exit_a_reg || id == exit_b_reg) id = 12'd1;
        dt = ($urandom_range(9) == 0) ? 64'd0 : 64'($urandom_range(5000));
        clock_ns += 64'($urandom_range(1, 200));
        send_word(MODE_ENTER, id, 1'b1, clock_ns);
        if ($urandom_range(19) == 0) begin
          send_word(MODE_EXIT, id, 1'b1, clock_ns - 64'($urandom_range(50)));
        end else begin
          send_word(MODE_EXIT, ($urandom_range(7) == 0) ? 12'($urandom_range(511)) : id,
                    1'b1, clock_ns + dt);
          clock_ns += dt;
        end
        n++;
      end else if (r < 93) begin
        send_word(2'($urandom_range(1)), 12'($urandom), ($urandom_range(3) == 0),
                  {$urandom, $urandom});
      end else if (r < 98) begin
        send_word(MODE_REPORT, 12'($urandom), 1'($urandom), {$urandom, $urandom});
      end else begin
        send_word(MODE_CLEAR, 12'($urandom), 1'($urandom), {$urandom, $urandom});
      end
    end
  endtask

  task automatic test_random();
    write_reg(REG_DEPTH, 12'd24);
    write_reg(REG_EXIT_A, 12'd17);
    write_reg(REG_EXIT_B, 12'd3000);
    run_random(90, 0);
    write_reg(REG_DEPTH, 12'd5);
    write_reg(REG_EXIT_B, 12'd300);
    run_random(90, 47);
    write_reg(REG_DEPTH, 12'd31);
    write_reg(REG_EXIT_A, 12'($urandom));
    run_random(90, 30);
    write_reg(REG_DEPTH, 12'd1);
    run_random(80, 0);
    send_word(MODE_REPORT, 12'd0, 1'b0, '0);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_registers();
    test_random();
    start <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("simulation failed");
    $finish;
  end
endmodule

@@ sim.f @@
sv/elp_pkg.sv
sv/elp_div.sv
sv/event_latency_profiler_top_n.sv
sv/elp_checker.sv
bench/testbench.sv
